// ===== rtl/psk_pkg.sv =====
// Shared types and constants of the process stack with keyed removal.
`default_nettype none
package psk_pkg;

   // Store sizing
   localparam int DEPTH = 16;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   // Field widths
   localparam int TAG_W  = 48;
   localparam int PRI_W  = 8;
   localparam int ID_W   = 22;
   localparam int TIME_W = 16;

   // Operation codes
   localparam logic [1:0] OP_PUSH    = 2'd0;
   localparam logic [1:0] OP_POP     = 2'd1;
   localparam logic [1:0] OP_DEL_TAG = 2'd2;
   localparam logic [1:0] OP_DEL_ID  = 2'd3;

   // One stored record
   typedef struct packed {
      logic [TAG_W-1:0]  tag;
      logic [PRI_W-1:0]  pri;
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] run;
   } rec_type;

   // Request beat
   typedef struct packed {
      logic [1:0]        opcode;
      logic [TAG_W-1:0]  name_tag;
      logic [PRI_W-1:0]  priority_req;
      logic [ID_W-1:0]   proc_id;
      logic [TIME_W-1:0] run_time;
   } req_type;

   // Response beat
   typedef struct packed {
      logic              found;
      logic [TAG_W-1:0]  out_name_tag;
      logic [PRI_W-1:0]  out_priority;
      logic [ID_W-1:0]   out_proc_id;
      logic [TIME_W-1:0] out_run_time;
      logic              is_empty;
      logic              overflow;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;
      logic scan_init;
      logic scan_step;
      logic hit_capture;
      logic shift_step;
      logic resp_push;
      logic resp_miss;
      logic resp_hit;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic op_push;
      logic empty;
      logic hit;
      logic scan_end;
      logic shift_done;
   } sts_type;

endpackage
`default_nettype wire

// ===== rtl/psk_datapath.sv =====
// Datapath: record memory, count, scan pointer, compare and response register.
`default_nettype none
module psk_datapath (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire psk_pkg::req_type req_data,
   input  wire psk_pkg::cmd_type cmd,
   output psk_pkg::sts_type      sts,
   output logic                 rsp_valid,
   output psk_pkg::rsp_type      rsp_data
);
   import psk_pkg::*;

   rec_type              mem_ff [DEPTH];
   req_type              req_ff;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     ptr_ff, ptr_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic [PTR_W-1:0]     rd_addr_ff, rd_addr_in;
   rec_type              rd_data_ff;
   rec_type              hit_rec_ff;
   logic                 rsp_vld_ff, rsp_vld_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 full;
   logic                 match;
   logic                 mem_we;
   logic [PTR_W-1:0]     wr_addr;
   rec_type              wr_data;
   rec_type              push_rec;

   assign full = (count_ff == CNT_W'(DEPTH));

   // Compare the word read last cycle against the key
   always_comb begin
      unique case (req_ff.opcode)
         OP_PUSH:    match = 1'b0;
         OP_POP:     match = 1'b1;
         OP_DEL_TAG: match = (rd_data_ff.tag == req_ff.name_tag);
         OP_DEL_ID:  match = (rd_data_ff.id == req_ff.proc_id);
         default:    match = 1'b0;
      endcase
   end

   assign sts.op_push    = (req_ff.opcode == OP_PUSH);
   assign sts.empty      = (count_ff == '0);
   assign sts.hit        = rd_vld_ff && match;
   assign sts.scan_end   = rd_vld_ff && !match && (rd_addr_ff == '0);
   assign sts.shift_done = !(ptr_ff < count_ff) && !rd_vld_ff;

   // Memory write port: push on top, or move an entry down while closing the gap
   always_comb begin
      push_rec.tag = req_ff.name_tag;
      push_rec.pri = req_ff.priority_req;
      push_rec.id  = req_ff.proc_id;
      push_rec.run = req_ff.run_time;
      mem_we  = 1'b0;
      wr_addr = count_ff[PTR_W-1:0];
      wr_data = push_rec;
      if (cmd.resp_push && !full) begin
         mem_we = 1'b1;
      end else if (cmd.shift_step && rd_vld_ff) begin
         mem_we  = 1'b1;
         wr_addr = rd_addr_ff - PTR_W'(1);
         wr_data = rd_data_ff;
      end
   end

   // Pointer, read tracking and count
   always_comb begin
      ptr_in     = ptr_ff;
      rd_vld_in  = rd_vld_ff;
      rd_addr_in = rd_addr_ff;
      count_in   = count_ff;
      if (cmd.scan_init) begin
         ptr_in    = count_ff - CNT_W'(1);
         rd_vld_in = 1'b0;
      end
      if (cmd.scan_step) begin
         ptr_in     = ptr_ff - CNT_W'(1);
         rd_vld_in  = 1'b1;
         rd_addr_in = ptr_ff[PTR_W-1:0];
      end
      if (cmd.hit_capture) begin
         ptr_in    = CNT_W'(rd_addr_ff) + CNT_W'(1);
         rd_vld_in = 1'b0;
      end
      if (cmd.shift_step) begin
         if (ptr_ff < count_ff) begin
            ptr_in     = ptr_ff + CNT_W'(1);
            rd_vld_in  = 1'b1;
            rd_addr_in = ptr_ff[PTR_W-1:0];
         end else begin
            rd_vld_in = 1'b0;
         end
      end
      if (cmd.resp_push && !full) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.resp_hit) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // Build the response beat
   always_comb begin
      rsp_in     = '0;
      rsp_vld_in = cmd.resp_push || cmd.resp_miss || cmd.resp_hit;
      if (cmd.resp_push) begin
         rsp_in.overflow = full;
      end
      if (cmd.resp_miss) begin
         rsp_in.is_empty = (count_ff == '0);
      end
      if (cmd.resp_hit) begin
         rsp_in.found        = 1'b1;
         rsp_in.out_name_tag = hit_rec_ff.tag;
         rsp_in.out_priority = hit_rec_ff.pri;
         rsp_in.out_proc_id  = hit_rec_ff.id;
         rsp_in.out_run_time = hit_rec_ff.run;
         rsp_in.is_empty     = (count_ff == CNT_W'(1));
      end
   end

   // Record memory with registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[ptr_ff[PTR_W-1:0]];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         rd_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         rd_vld_ff  <= rd_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      ptr_ff     <= ptr_in;
      rd_addr_ff <= rd_addr_in;
      rsp_ff     <= rsp_in;
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.hit_capture) begin
         hit_rec_ff <= rd_data_ff;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   // Count never exceeds the store depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   // A removal takes exactly one entry away
   a_hit_dec: assert property (@(posedge clock) disable iff (reset)
      cmd.resp_hit |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("removal did not decrement count");

   // Gap closing only writes inside the live region
   a_shift_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.shift_step && rd_vld_ff) |-> CNT_W'(wr_addr) < count_ff)
      else $error("shift write outside held entries");

endmodule
`default_nettype wire

// ===== rtl/psk_ctrl.sv =====
// Controller: sequences dispatch, top-down search and gap closing.
`default_nettype none
module psk_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   input  wire psk_pkg::sts_type sts,
   output psk_pkg::cmd_type      cmd
);
   import psk_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE     = 4'b0001,
      ST_DISPATCH = 4'b0010,
      ST_SEARCH   = 4'b0100,
      ST_SHIFT    = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (sts.op_push) begin
               cmd.resp_push = 1'b1;
               state_in      = ST_IDLE;
            end else if (sts.empty) begin
               cmd.resp_miss = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (sts.hit) begin
               cmd.hit_capture = 1'b1;
               state_in        = ST_SHIFT;
            end else if (sts.scan_end) begin
               cmd.resp_miss = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_SHIFT: begin
            if (sts.shift_done) begin
               cmd.resp_hit = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               cmd.shift_step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // A beat is taken only from idle and always leads to dispatch
   a_load_dispatch: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_DISPATCH)
      else $error("accepted beat not dispatched");

   // At most one response command per cycle
   a_one_resp: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.resp_push, cmd.resp_miss, cmd.resp_hit}))
      else $error("several responses in one cycle");

   // Every response returns the controller to idle
   a_resp_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.resp_push || cmd.resp_miss || cmd.resp_hit) |=> state_ff == ST_IDLE)
      else $error("response without return to idle");

endmodule
`default_nettype wire

// ===== rtl/process_stack_keyed_remove_top.sv =====
// Top level of the process stack with keyed removal.
//
//   channel    ports                    beat taken when
//   request    start, busy, req_data    start high and busy low at a clock edge
//   response   rsp_valid, rsp_data      rsp_valid high (one cycle, no stall)
//
// Push and an empty pop or delete are answered from the dispatch state after accept.
// A pop or delete walks the search state from the top down, and a hit then closes the
// gap in the shift state, both set by the single-read, single-write record memory
// walked one entry per cycle.
// Reset clears the count and control state; the store itself is not cleared.
// The response strobe lasts one cycle and cannot be held off by the receiver.
`default_nettype none
module process_stack_keyed_remove_top (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   input  wire psk_pkg::req_type req_data,
   output logic                 rsp_valid,
   output psk_pkg::rsp_type      rsp_data
);
   import psk_pkg::*;

   cmd_type cmd;
   sts_type sts;

   psk_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   psk_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire
